FILE: sv/http_request_head_parser_assert.svh
// assertion macros shared by the checker of the http request head parser
// no dependencies; included by the checker file
`ifndef HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, quiet during reset
`define HRHP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrhp assertion failed");

// next-cycle implication, sampled on the rising edge, quiet during reset
`define HRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrhp assertion failed");

`endif

FILE: sv/hrhp_pkg.sv
// types, character codes and keyword tables of the http request head parser
// no dependencies; used by hrhp_step, http_request_head_parser and hrhp_checker
`timescale 1ns / 1ps

package hrhp_pkg;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [3:0] METHOD_LEN  = 4'd3;
    localparam logic [3:0] VERSION_LEN = 4'd8;
    localparam logic [3:0] SCHEME_LEN  = 4'd7;
    localparam logic [3:0] HOST_LEN    = 4'd5;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_SEP1,
        PH_URL,
        PH_SEP2,
        PH_VERSION,
        PH_HEADERS
    } t_phase;

    typedef enum logic [1:0] {
        URL_UNDECIDED,
        URL_GOOD,
        URL_WAIT_SLASH,
        URL_BAD
    } t_url;

    typedef enum logic [1:0] {
        HDR_MATCH,
        HDR_SKIP_SEP,
        HDR_VALUE,
        HDR_OTHER
    } t_hdr;

    typedef enum logic [1:0] {
        OUT_RUNNING,
        OUT_COMPLETE,
        OUT_BAD
    } t_outcome;

    typedef enum logic [2:0] {
        ROLE_OTHER,
        ROLE_METHOD,
        ROLE_URL,
        ROLE_VERSION,
        ROLE_HOST
    } t_role;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] match_pos;
        logic       mismatch;
        t_url       url;
        logic       pending_cr;
        t_hdr       hdr;
        logic       line_has_bytes;
        t_outcome   outcome;
    } t_parse_state;

    typedef struct packed {
        t_outcome status;
        t_role    role;
        logic     line_end;
        logic     host_line;
    } t_result;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {["A":"Z"]}) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] method_char(input logic [1:0] pos);
        logic [7:0] r;
        case (pos)
            2'd0:    r = "g";
            2'd1:    r = "e";
            2'd2:    r = "t";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = "h";
            3'd1:    r = "t";
            3'd2:    r = "t";
            3'd3:    r = "p";
            3'd4:    r = "/";
            3'd5:    r = "1";
            3'd6:    r = ".";
            3'd7:    r = "1";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] scheme_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = "h";
            3'd1:    r = "t";
            3'd2:    r = "t";
            3'd3:    r = "p";
            3'd4:    r = ":";
            3'd5:    r = "/";
            3'd6:    r = "/";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] host_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = "h";
            3'd1:    r = "o";
            3'd2:    r = "s";
            3'd3:    r = "t";
            3'd4:    r = ":";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/http_request_head_parser.sv
// http request head parser: checks request line and headers, tags each byte
// Input channel: i_in_valid / o_in_stall carry one request byte and a restart
// flag per transaction; restart clears the parse state before that byte.
// Output channel: o_out_valid / i_out_stall carry one result per byte: status,
// byte role, line end and host header line.
// A byte passes from the input register through the parse step into the result
// register, which drives the outputs.
// Throughput: one byte per cycle while the receiver does not stall; the
// parse state update is a single pass of logic between the two registers.
// When the receiver stalls, the result holds and the byte waiting in the input
// register stays there; o_in_stall rises only once both registers are full.
// Reset (i_rst_n low at an edge) empties both registers, clears the parse
// state and sets the separator register back to tab only.
// i_cfg_wr_en writes i_cfg_wr_data into the separator register (1: space also
// separates fields); write it only while no transaction is in flight.
// depends on hrhp_pkg and hrhp_step
`timescale 1ns / 1ps

module http_request_head_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_restart,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [2:0] o_byte_role,
    output logic       o_line_end,
    output logic       o_host_header_line
);
    import hrhp_pkg::*;

    logic         r_space_en;
    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_restart;
    logic         r_out_valid;
    t_result      r_result;
    t_parse_state r_state;

    t_parse_state cur_state;
    t_parse_state n_state;
    t_result      n_result;
    logic         move_out;
    logic         in_take;

    // result register free or draining this cycle
    assign move_out   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move_out;
    assign in_take    = i_in_valid && !o_in_stall;

    assign cur_state = r_in_restart ? t_parse_state'('0) : r_state;

    hrhp_step u_step (
        .i_state     (cur_state),
        .i_data_byte (r_in_byte),
        .i_space_en  (r_space_en),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_en <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_space_en <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (move_out) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte    <= i_data_byte;
            r_in_restart <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (move_out) begin
            r_out_valid <= 1'b1;
            r_state     <= n_state;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_out) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_result.status;
    assign o_byte_role        = r_result.role;
    assign o_line_end         = r_result.line_end;
    assign o_host_header_line = r_result.host_line;

endmodule

FILE: sv/hrhp_step.sv
// per-byte parse step: next parse state and byte result from current state
// depends on hrhp_pkg
`timescale 1ns / 1ps

module hrhp_step (
    input  hrhp_pkg::t_parse_state i_state,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_space_en,
    output hrhp_pkg::t_parse_state o_state,
    output hrhp_pkg::t_result      o_result
);
    import hrhp_pkg::*;

    t_parse_state st;
    t_parse_state nst;
    t_result      res;
    logic [7:0]   fc;
    logic         sep;
    logic         host_line;
    logic         do_url;
    t_url         ub_url;
    logic [3:0]   ub_pos;
    logic         do_ver;
    logic [3:0]   vb_pos;

    assign st = i_state;

    always_comb begin
        nst       = st;
        res       = '0;
        res.role  = ROLE_OTHER;
        fc        = fold(i_data_byte);
        sep       = (i_data_byte == CH_TAB) || (i_space_en && (i_data_byte == CH_SPACE));
        host_line = (st.phase == PH_HEADERS) &&
                    ((st.hdr == HDR_SKIP_SEP) || (st.hdr == HDR_VALUE));
        do_url    = 1'b0;
        ub_url    = st.url;
        ub_pos    = st.match_pos;
        do_ver    = 1'b0;
        vb_pos    = st.match_pos;

        if (st.outcome == OUT_RUNNING) begin
            if (st.pending_cr) begin
                nst.pending_cr = 1'b0;
                if (i_data_byte != CH_LF) begin
                    nst.outcome = OUT_BAD;
                end else if (st.phase != PH_HEADERS) begin
                    if ((st.phase == PH_VERSION) && !st.mismatch &&
                        (st.match_pos == VERSION_LEN)) begin
                        nst.phase          = PH_HEADERS;
                        nst.match_pos      = 4'd0;
                        nst.hdr            = HDR_MATCH;
                        nst.line_has_bytes = 1'b0;
                        res.line_end       = 1'b1;
                    end else begin
                        nst.outcome = OUT_BAD;
                    end
                end else if (!st.line_has_bytes) begin
                    // blank line ends the head
                    nst.outcome  = OUT_COMPLETE;
                    res.line_end = 1'b1;
                end else begin
                    res.line_end       = 1'b1;
                    res.host_line      = host_line;
                    nst.match_pos      = 4'd0;
                    nst.hdr            = HDR_MATCH;
                    nst.line_has_bytes = 1'b0;
                end
            end else if (i_data_byte == CH_LF) begin
                nst.outcome = OUT_BAD;
            end else if (i_data_byte == CH_CR) begin
                nst.pending_cr = 1'b1;
                res.host_line  = host_line;
            end else begin
                case (st.phase)
                    PH_METHOD: begin
                        if (sep) begin
                            if (st.match_pos != METHOD_LEN) begin
                                nst.mismatch = 1'b1;
                            end
                            nst.phase = PH_SEP1;
                        end else begin
                            if ((st.match_pos < METHOD_LEN) &&
                                (fc == method_char(st.match_pos[1:0]))) begin
                                nst.match_pos = st.match_pos + 4'd1;
                            end else begin
                                nst.mismatch = 1'b1;
                            end
                            res.role = ROLE_METHOD;
                        end
                    end
                    PH_SEP1: begin
                        if (!sep) begin
                            nst.phase = PH_URL;
                            do_url    = 1'b1;
                            ub_url    = URL_UNDECIDED;
                            ub_pos    = 4'd0;
                            res.role  = ROLE_URL;
                        end
                    end
                    PH_URL: begin
                        if (sep) begin
                            if (st.url != URL_GOOD) begin
                                nst.mismatch = 1'b1;
                            end
                            nst.phase = PH_SEP2;
                        end else begin
                            do_url   = 1'b1;
                            res.role = ROLE_URL;
                        end
                    end
                    PH_SEP2: begin
                        if (!sep) begin
                            nst.phase = PH_VERSION;
                            do_ver    = 1'b1;
                            vb_pos    = 4'd0;
                            res.role  = ROLE_VERSION;
                        end
                    end
                    PH_VERSION: begin
                        // separators here are version bytes too
                        do_ver   = 1'b1;
                        res.role = ROLE_VERSION;
                    end
                    default: begin
                        nst.line_has_bytes = 1'b1;
                        if (st.hdr == HDR_MATCH) begin
                            if ((st.match_pos < HOST_LEN) &&
                                (fc == host_char(st.match_pos[2:0]))) begin
                                nst.match_pos = st.match_pos + 4'd1;
                                if (st.match_pos + 4'd1 == HOST_LEN) begin
                                    nst.hdr = HDR_SKIP_SEP;
                                end
                            end else begin
                                nst.hdr = HDR_OTHER;
                            end
                        end else if (st.hdr == HDR_SKIP_SEP) begin
                            if (!sep) begin
                                nst.hdr  = HDR_VALUE;
                                res.role = ROLE_HOST;
                            end
                        end else if (st.hdr == HDR_VALUE) begin
                            res.role = ROLE_HOST;
                        end
                    end
                endcase

                if (do_url) begin
                    nst.url       = ub_url;
                    nst.match_pos = ub_pos;
                    if (ub_url == URL_UNDECIDED) begin
                        if ((ub_pos == 4'd0) && (i_data_byte == CH_SLASH)) begin
                            nst.url = URL_GOOD;
                        end else if ((ub_pos < SCHEME_LEN) &&
                                     (fc == scheme_char(ub_pos[2:0]))) begin
                            nst.match_pos = ub_pos + 4'd1;
                            if (ub_pos + 4'd1 == SCHEME_LEN) begin
                                nst.url = URL_WAIT_SLASH;
                            end
                        end else begin
                            nst.url = URL_BAD;
                        end
                    end else if ((ub_url == URL_WAIT_SLASH) && (i_data_byte == CH_SLASH)) begin
                        nst.url = URL_GOOD;
                    end
                end

                if (do_ver) begin
                    nst.match_pos = vb_pos;
                    if ((vb_pos < VERSION_LEN) && (fc == version_char(vb_pos[2:0]))) begin
                        nst.match_pos = vb_pos + 4'd1;
                    end else begin
                        nst.mismatch = 1'b1;
                    end
                end

                res.host_line = (nst.phase == PH_HEADERS) &&
                                ((nst.hdr == HDR_SKIP_SEP) || (nst.hdr == HDR_VALUE));
            end

            if (nst.outcome != OUT_RUNNING) begin
                res.role      = ROLE_OTHER;
                res.host_line = 1'b0;
                if (nst.outcome == OUT_BAD) begin
                    res.line_end = 1'b0;
                end
            end
        end

        res.status = nst.outcome;
    end

    assign o_state  = nst;
    assign o_result = res;

endmodule

FILE: sv/hrhp_checker.sv
// port-level checks of the http request head parser, bound to the top level
// depends on hrhp_pkg and http_request_head_parser_assert.svh
`timescale 1ns / 1ps

`include "http_request_head_parser_assert.svh"

module hrhp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_status,
    input logic [2:0] o_byte_role,
    input logic       o_line_end,
    input logic       o_host_header_line
);
    import hrhp_pkg::*;

    // a bad request carries nothing else
    `HRHP_ASSERT_IMPLY(a_bad_clean, i_clk, i_rst_n, o_out_valid && (o_status == OUT_BAD), (o_byte_role == ROLE_OTHER) && !o_line_end && !o_host_header_line)

    // a finished request tags no byte
    `HRHP_ASSERT_IMPLY(a_done_untagged, i_clk, i_rst_n, o_out_valid && (o_status == OUT_COMPLETE), (o_byte_role == ROLE_OTHER) && !o_host_header_line)

    `HRHP_ASSERT_IMPLY(a_status_code, i_clk, i_rst_n, o_out_valid, (o_status == OUT_RUNNING) || (o_status == OUT_COMPLETE) || (o_status == OUT_BAD))

    // the lf ending a line is never a field byte
    `HRHP_ASSERT_IMPLY(a_lf_role, i_clk, i_rst_n, o_out_valid && o_line_end, o_byte_role == ROLE_OTHER)

    `HRHP_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_byte_role) && $stable(o_line_end) && $stable(o_host_header_line))

endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_status           (o_status),
    .o_byte_role        (o_byte_role),
    .o_line_end         (o_line_end),
    .o_host_header_line (o_host_header_line)
);
